/* rtl/core/tad_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_pkg
// Shared widths, codes and control structs of the three-axis average decimator.
// ----------------------------------------------------------------------------
package tad_pkg;

	localparam int SAMPLE_BITS_DEF = 20;
	localparam int FACT_W          = 8;
	localparam int CFG_W           = 8;
	localparam int TICK_W          = 32;
	localparam int REG_IDX_W       = 1;

	localparam logic [REG_IDX_W-1:0] REG_DECIM = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_BATCH = 1'd1;

	localparam logic [CFG_W-1:0] DECIM_RST = 8'd20;
	localparam logic [CFG_W-1:0] BATCH_RST = 8'd200;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	// group status from the accumulator, valid in the cycle of a sample word
	typedef struct packed {
		logic              close;
		logic              last;
		logic [TICK_W-1:0] tick;
	} acc_stat_t;

	// divider sequencing from the top level
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

endpackage

/* rtl/core/three_axis_average_decimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_average_decimator
// Boxcar average decimator for three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Input words (in_valid / in_stall) carry func, three signed samples and a
// capture tick; func clear empties the sums and both counters and gives no
// output. Each sample adds into the sums. When a group of
// decimation_factor samples is complete, the three bit-serial dividers work
// out one quotient bit per cycle, and the averages with the group's first
// tick and the batch_last flag are loaded into the output register
// (out_valid / out_stall).
// A sample that does not close a group is taken without stalling the input;
// one that closes a group raises in_stall while the dividers work and until
// the averages are loaded into the output register. While the output word
// waits under out_stall, further samples are still taken until a group
// closes; a finished quotient is then held in the dividers until the
// register frees. Reset: sums and counters cleared, decimation_factor 20,
// batch_length 200. Configuration is written through cfg_we / cfg_index /
// cfg_data; the user must do so only when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module three_axis_average_decimator #(
	parameter int SAMPLE_BITS = tad_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tad_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [tad_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic signed [SAMPLE_BITS-1:0]    sample_x,
	input  logic signed [SAMPLE_BITS-1:0]    sample_y,
	input  logic signed [SAMPLE_BITS-1:0]    sample_z,
	input  logic [tad_pkg::TICK_W-1:0]       capture_tick,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [SAMPLE_BITS-1:0]    mean_x,
	output logic signed [SAMPLE_BITS-1:0]    mean_y,
	output logic signed [SAMPLE_BITS-1:0]    mean_z,
	output logic [tad_pkg::TICK_W-1:0]       group_tick,
	output logic                             batch_last
);
	import tad_pkg::*;

	localparam int SUM_W = SAMPLE_BITS + FACT_W;
	localparam int CNT_W = $clog2(SUM_W + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV  = 1'b1;

	logic                    state_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CFG_W-1:0]        decim_q;
	logic [CFG_W-1:0]        batch_q;
	logic [FACT_W-1:0]       fac_eff;
	logic [CFG_W-1:0]        blen_eff;
	logic                    accept;
	logic                    is_clear;
	logic                    close_go;
	logic                    out_load;
	acc_stat_t               stat;
	div_ctl_t                dctl;
	logic signed [SUM_W-1:0] sum_x, sum_y, sum_z;
	logic signed [SAMPLE_BITS-1:0] q_x, q_y, q_z;
	logic [TICK_W-1:0]       tick_q;
	logic                    last_q;
	logic                    out_valid_q;
	logic signed [SAMPLE_BITS-1:0] mean_x_q, mean_y_q, mean_z_q;
	logic [TICK_W-1:0]       group_tick_q;
	logic                    batch_last_q;

	// a zero register value behaves as one
	assign fac_eff  = (decim_q == '0) ? FACT_W'(1) : decim_q;
	assign blen_eff = (batch_q == '0) ? CFG_W'(1) : batch_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign is_clear  = (func == FUNC_CLEAR);
	assign close_go  = accept & ~is_clear & stat.close;
	assign dctl.load = close_go;
	assign dctl.step = (state_q == ST_DIV) && (cnt_q != '0);
	assign out_load  = (state_q == ST_DIV) && (cnt_q == '0) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decim_q <= DECIM_RST;
			batch_q <= BATCH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DECIM: decim_q <= cfg_data;
				REG_BATCH: batch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tad_accum #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.SUM_W       (SUM_W)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (accept),
		.clear    (is_clear),
		.sample_x (sample_x),
		.sample_y (sample_y),
		.sample_z (sample_z),
		.tick     (capture_tick),
		.factor   (fac_eff),
		.blen     (blen_eff),
		.sum_x    (sum_x),
		.sum_y    (sum_y),
		.sum_z    (sum_z),
		.stat     (stat)
	);

	tad_div #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_div_x (
		.clk    (clk),
		.ctl    (dctl),
		.sum    (sum_x),
		.factor (fac_eff),
		.mean   (q_x)
	);

	tad_div #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_div_y (
		.clk    (clk),
		.ctl    (dctl),
		.sum    (sum_y),
		.factor (fac_eff),
		.mean   (q_y)
	);

	tad_div #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_W(SUM_W)) u_div_z (
		.clk    (clk),
		.ctl    (dctl),
		.sum    (sum_z),
		.factor (fac_eff),
		.mean   (q_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (close_go) begin
						state_q <= ST_DIV;
						cnt_q   <= CNT_W'(SUM_W);
					end
				end
				ST_DIV: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CNT_W'(1);
					end else if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// group tick and batch flag wait here while the dividers run
	always_ff @(posedge clk) begin
		if (close_go) begin
			tick_q <= stat.tick;
			last_q <= stat.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mean_x_q     <= q_x;
			mean_y_q     <= q_y;
			mean_z_q     <= q_z;
			group_tick_q <= tick_q;
			batch_last_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign mean_x     = mean_x_q;
	assign mean_y     = mean_y_q;
	assign mean_z     = mean_z_q;
	assign group_tick = group_tick_q;
	assign batch_last = batch_last_q;

endmodule

/* rtl/core/tad_accum.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_accum
// Per-axis running sums, group and batch counters, and first-tick hold.
// ----------------------------------------------------------------------------
module tad_accum #(
	parameter int SAMPLE_BITS = tad_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + tad_pkg::FACT_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             take,
	input  logic                             clear,
	input  logic signed [SAMPLE_BITS-1:0]    sample_x,
	input  logic signed [SAMPLE_BITS-1:0]    sample_y,
	input  logic signed [SAMPLE_BITS-1:0]    sample_z,
	input  logic [tad_pkg::TICK_W-1:0]       tick,
	input  logic [tad_pkg::FACT_W-1:0]       factor,
	input  logic [tad_pkg::CFG_W-1:0]        blen,
	output logic signed [SUM_W-1:0]          sum_x,
	output logic signed [SUM_W-1:0]          sum_y,
	output logic signed [SUM_W-1:0]          sum_z,
	output tad_pkg::acc_stat_t               stat
);
	import tad_pkg::*;

	logic signed [SUM_W-1:0] sum_x_q, sum_y_q, sum_z_q;
	logic [FACT_W-1:0]       group_cnt_q;
	logic [CFG_W-1:0]        batch_cnt_q;
	logic [TICK_W-1:0]       first_tick_q;
	logic [FACT_W:0]         group_inc;
	logic [CFG_W:0]          batch_inc;

	assign sum_x = sum_x_q + {{(SUM_W-SAMPLE_BITS){sample_x[SAMPLE_BITS-1]}}, sample_x};
	assign sum_y = sum_y_q + {{(SUM_W-SAMPLE_BITS){sample_y[SAMPLE_BITS-1]}}, sample_y};
	assign sum_z = sum_z_q + {{(SUM_W-SAMPLE_BITS){sample_z[SAMPLE_BITS-1]}}, sample_z};

	assign group_inc  = {1'b0, group_cnt_q} + (FACT_W+1)'(1);
	assign batch_inc  = {1'b0, batch_cnt_q} + (CFG_W+1)'(1);
	assign stat.close = group_inc >= {1'b0, factor};
	assign stat.last  = batch_inc >= {1'b0, blen};
	assign stat.tick  = (group_cnt_q == '0) ? tick : first_tick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_z_q      <= '0;
			group_cnt_q  <= '0;
			batch_cnt_q  <= '0;
			first_tick_q <= '0;
		end else if (take) begin
			if (clear) begin
				sum_x_q     <= '0;
				sum_y_q     <= '0;
				sum_z_q     <= '0;
				group_cnt_q <= '0;
				batch_cnt_q <= '0;
			end else begin
				if (group_cnt_q == '0) begin
					first_tick_q <= tick;
				end
				if (stat.close) begin
					sum_x_q     <= '0;
					sum_y_q     <= '0;
					sum_z_q     <= '0;
					group_cnt_q <= '0;
					batch_cnt_q <= stat.last ? '0 : batch_inc[CFG_W-1:0];
				end else begin
					sum_x_q     <= sum_x;
					sum_y_q     <= sum_y;
					sum_z_q     <= sum_z;
					group_cnt_q <= group_inc[FACT_W-1:0];
				end
			end
		end
	end

endmodule

/* rtl/core/tad_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_div
// Bit-serial restoring divider: signed group sum by the unsigned factor,
// one quotient bit per cycle while ctl.step is high, truncated toward zero.
// ----------------------------------------------------------------------------
module tad_div #(
	parameter int SAMPLE_BITS = tad_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_W       = SAMPLE_BITS + tad_pkg::FACT_W
) (
	input  logic                          clk,
	input  tad_pkg::div_ctl_t             ctl,
	input  logic signed [SUM_W-1:0]       sum,
	input  logic [tad_pkg::FACT_W-1:0]    factor,
	output logic signed [SAMPLE_BITS-1:0] mean
);
	import tad_pkg::*;

	// dividend shifts out msb first, quotient bits shift in at the lsb
	logic [SUM_W-1:0]       dvd_q;
	logic [FACT_W-1:0]      rem_q;
	logic [FACT_W-1:0]      fac_q;
	logic                   neg_q;
	logic [FACT_W:0]        trial;
	logic [FACT_W:0]        diff;
	logic                   ge;
	logic [SAMPLE_BITS-1:0] quo;

	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, fac_q};
	assign diff  = trial - {1'b0, fac_q};
	assign quo   = dvd_q[SAMPLE_BITS-1:0];
	assign mean  = neg_q ? -quo : quo;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			neg_q <= sum[SUM_W-1];
			dvd_q <= sum[SUM_W-1] ? -sum : sum;
			rem_q <= '0;
			fac_q <= factor;
		end else if (ctl.step) begin
			rem_q <= ge ? diff[FACT_W-1:0] : trial[FACT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
	end

endmodule

/* rtl/core/tad_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tad_checker
// Port-level checks of the three-axis average decimator, bound to the top.
// ----------------------------------------------------------------------------
module tad_checker #(
	parameter int SAMPLE_BITS = tad_pkg::SAMPLE_BITS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          func,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [SAMPLE_BITS-1:0]        mean_x,
	input logic [tad_pkg::TICK_W-1:0]    group_tick,
	input logic                          batch_last
);
	import tad_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(mean_x)
			&& $stable(group_tick) && $stable(batch_last))
		else $error("output word changed under stall");

	// a clear word never starts the dividers
	a_clear_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func == FUNC_CLEAR |=> !in_stall)
		else $error("clear word stalled the input");

	// the input stalls only after a word was taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("input stall without an accepted word");

	// a new result appears only as the divide finishes
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall) && !in_stall)
		else $error("output word without a finished divide");

endmodule

bind three_axis_average_decimator tad_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tad_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.func       (func),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.mean_x     (mean_x),
	.group_tick (group_tick),
	.batch_last (batch_last)
);

/* dv/tb_three_axis_average_decimator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_axis_average_decimator
// Self-checking bench for the three-axis boxcar average decimator. A queue-fed
// driver offers sample and clear words under random gaps. A monitor predicts
// every average from its own model of the sums, group and batch counters.
// Each word it takes off the output is compared field by field. Directed words
// cover the sample and tick extremes, rounding toward zero, clears mid-group,
// zero register values, factor lowered mid-group and batch length lowered
// mid-batch. Random segments then sweep register settings under three idle
// mixes, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_three_axis_average_decimator;

	import tad_pkg::*;

	localparam int SB       = SAMPLE_BITS_DEF;
	localparam int PERIOD   = 20;
	localparam int LAT      = SB + 20;
	localparam int LIMIT    = 1000000;
	localparam int HOLD_LEN = 400;

	typedef logic signed [SB-1:0] sample_t;

	localparam sample_t S_MIN = {1'b1, {(SB-1){1'b0}}};
	localparam sample_t S_MAX = {1'b0, {(SB-1){1'b1}}};

	typedef struct {
		logic              func;
		sample_t           x;
		sample_t           y;
		sample_t           z;
		logic [TICK_W-1:0] tick;
	} accel_word_t;

	typedef struct {
		sample_t           mx;
		sample_t           my;
		sample_t           mz;
		logic [TICK_W-1:0] tick;
		logic              last;
	} mean_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_DECIM;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 func = FUNC_SAMPLE;
	sample_t              sample_x = '0;
	sample_t              sample_y = '0;
	sample_t              sample_z = '0;
	logic [TICK_W-1:0]    capture_tick = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sample_t              mean_x;
	sample_t              mean_y;
	sample_t              mean_z;
	logic [TICK_W-1:0]    group_tick;
	logic                 batch_last;

	three_axis_average_decimator #(
		.SAMPLE_BITS(SB)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.sample_x     (sample_x),
		.sample_y     (sample_y),
		.sample_z     (sample_z),
		.capture_tick (capture_tick),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.mean_x       (mean_x),
		.mean_y       (mean_y),
		.mean_z       (mean_z),
		.group_tick   (group_tick),
		.batch_last   (batch_last)
	);

	always #(PERIOD / 2) clk = ~clk;

	// pending words and expected averages
	accel_word_t word_q[$];
	mean_word_t  mean_q[$];

	// model of the decimator
	logic [CFG_W-1:0]  decim_reg = DECIM_RST;
	logic [CFG_W-1:0]  batch_reg = BATCH_RST;
	logic [7:0]        grp_cnt = '0;
	longint            acc_x = 0;
	longint            acc_y = 0;
	longint            acc_z = 0;
	logic [TICK_W-1:0] first_tick = '0;
	logic [7:0]        batch_cnt = '0;

	int gap_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int cycle_cnt = 0;
	int words_in = 0;
	int means_checked = 0;
	int reg_writes = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit hold_seen = 1'b0;
	bit in_fire = 1'b0;

	accel_word_t next_word;
	accel_word_t cur_word;
	mean_word_t  exp_mean;
	mean_word_t  new_mean;

	function automatic bit average_step(input accel_word_t w, output mean_word_t m);
		int fac;
		int blen;
		fac  = (decim_reg == 0) ? 1 : int'(decim_reg);
		blen = (batch_reg == 0) ? 1 : int'(batch_reg);
		m = '{default: '0};
		if (w.func == FUNC_CLEAR) begin
			grp_cnt   = '0;
			acc_x     = 0;
			acc_y     = 0;
			acc_z     = 0;
			batch_cnt = '0;
			return 1'b0;
		end
		if (grp_cnt == 0)
			first_tick = w.tick;
		acc_x   = acc_x + w.x;
		acc_y   = acc_y + w.y;
		acc_z   = acc_z + w.z;
		grp_cnt = grp_cnt + 8'd1;
		if (int'(grp_cnt) < fac)
			return 1'b0;
		// signed divide truncates toward zero
		m.mx      = sample_t'(acc_x / fac);
		m.my      = sample_t'(acc_y / fac);
		m.mz      = sample_t'(acc_z / fac);
		m.tick    = first_tick;
		grp_cnt   = '0;
		acc_x     = 0;
		acc_y     = 0;
		acc_z     = 0;
		batch_cnt = batch_cnt + 8'd1;
		if (int'(batch_cnt) >= blen) begin
			m.last    = 1'b1;
			batch_cnt = '0;
		end else begin
			m.last = 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
		if (want !== seen) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, what, want, seen);
		end
	endtask

	// driver: a word stays on the port until it is taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (word_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				next_word = word_q.pop_front();
				in_valid     <= 1'b1;
				func         <= next_word.func;
				sample_x     <= next_word.x;
				sample_y     <= next_word.y;
				sample_z     <= next_word.z;
				capture_tick <= next_word.tick;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("%0t: run stopped after %0d cycles", $time, cycle_cnt);
			$display("*** FAILED ***");
			$finish;
		end else begin
			in_fire <= in_valid && !in_stall;
			if (cfg_we) begin
				case (cfg_index)
					REG_DECIM: decim_reg = cfg_data;
					REG_BATCH: batch_reg = cfg_data;
					default: ;
				endcase
			end
			if (arst_n && out_valid && !out_stall) begin
				if (mean_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word, expected none actual %h %h %h %h %b",
						$time, mean_x, mean_y, mean_z, group_tick, batch_last);
				end else begin
					exp_mean = mean_q.pop_front();
					check_field("mean_x", exp_mean.mx, mean_x);
					check_field("mean_y", exp_mean.my, mean_y);
					check_field("mean_z", exp_mean.mz, mean_z);
					check_field("group_tick", exp_mean.tick, group_tick);
					check_field("batch_last", exp_mean.last, batch_last);
					means_checked++;
				end
			end
			if (arst_n && in_valid && !in_stall) begin
				cur_word = '{func, sample_x, sample_y, sample_z, capture_tick};
				if (average_step(cur_word, new_mean))
					mean_q.push_back(new_mean);
				words_in++;
			end
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MIN;
			1: return S_MAX;
			2: return sample_t'($urandom_range(0, 4)) - sample_t'(2);
			default: return sample_t'($urandom());
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] pick_tick();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic void push_sample(sample_t x, sample_t y, sample_t z,
		logic [TICK_W-1:0] t);
		word_q.push_back('{FUNC_SAMPLE, x, y, z, t});
	endfunction

	function automatic void push_clear();
		word_q.push_back('{FUNC_CLEAR, pick_sample(), pick_sample(), pick_sample(), pick_tick()});
	endfunction

	function automatic int pick_factor();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return 255;
			2, 3: return 1;
			4: return 2;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_batch();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 255;
			2: return 1;
			3: return 200;
			default: return $urandom_range(2, 8);
		endcase
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		reg_writes++;
		@(posedge clk);
	endtask

	// wait for all words taken and all averages seen, then let a partial group settle
	task automatic settle();
		while (word_q.size() != 0 || in_valid || mean_q.size() != 0)
			@(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic run_segment(int fac, int blen, int n);
		write_reg(REG_DECIM, fac[CFG_W-1:0]);
		write_reg(REG_BATCH, blen[CFG_W-1:0]);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 4)
				push_clear();
			else
				push_sample(pick_sample(), pick_sample(), pick_sample(), pick_tick());
		end
		settle();
	endtask

	initial begin
		int fac;
		int blen;
		int n;
		int phase_items;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_pct   = 15;
		stall_pct = 54;

		// every word is its own group, batches of three
		write_reg(REG_DECIM, 8'd1);
		write_reg(REG_BATCH, 8'd3);
		push_sample(S_MAX, S_MIN, '0, '0);
		push_sample(S_MIN, S_MAX, -1, '1);
		push_sample(1, -1, '0, 32'h8000_0001);
		settle();

		// pairs: extremes, and rounding of negative sums toward zero
		write_reg(REG_DECIM, 8'd2);
		push_sample(S_MAX, S_MAX, S_MAX, 32'h0000_0010);
		push_sample(S_MAX, S_MAX, S_MAX, 32'h0000_0011);
		push_sample(S_MIN, S_MIN, S_MIN, 32'hFFFF_FFF0);
		push_sample(S_MIN, S_MIN, S_MIN, 32'hFFFF_FFF1);
		push_sample(-1, -1, 1, 32'h1234_5678);
		push_sample('0, '0, '0, 32'h1234_5679);
		push_sample(-3, 3, -3, 32'h0BAD_0000);
		push_sample('0, '0, -2, 32'h0BAD_0001);
		// clear in the middle of a group
		push_sample(S_MAX, S_MAX, S_MAX, 32'hAAAA_0000);
		push_clear();
		push_sample(5, -7, 9, 32'hAAAA_0001);
		push_sample(-6, 8, 100, 32'hAAAA_0002);
		settle();

		// zero factor and zero batch length act as one
		write_reg(REG_DECIM, 8'd0);
		write_reg(REG_BATCH, 8'd0);
		push_sample(123, -456, 789, 32'h5555_5555);
		push_sample(S_MIN, 0, S_MAX, 32'hCAFE_0000);
		settle();

		// factor lowered while a group is open
		write_reg(REG_DECIM, 8'd4);
		write_reg(REG_BATCH, 8'd5);
		push_sample(S_MAX, -100, 7, 32'h0000_0100);
		push_sample(S_MAX, -101, 8, 32'h0000_0101);
		settle();
		write_reg(REG_DECIM, 8'd2);
		push_sample(S_MAX, -102, 9, 32'h0000_0102);
		settle();

		// batch length lowered while a batch is open
		write_reg(REG_DECIM, 8'd1);
		push_sample(10, 20, 30, 32'h0000_0200);
		push_sample(11, 21, 31, 32'h0000_0201);
		settle();
		write_reg(REG_BATCH, 8'd2);
		push_sample(12, 22, 32, 32'h0000_0202);
		settle();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					gap_pct   = 15;
					stall_pct = 54;
				end
				1: begin
					gap_pct   = 54;
					stall_pct = 15;
				end
				default: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
			endcase
			if (phase == 0) begin
				// widest group at full scale
				write_reg(REG_DECIM, 8'd255);
				write_reg(REG_BATCH, 8'd2);
				for (int i = 0; i < 255; i++)
					push_sample(S_MAX, S_MIN, pick_sample(), pick_tick());
				settle();
			end
			if (phase == 2) begin
				// hold the output long enough for the input to back up
				write_reg(REG_DECIM, 8'd1);
				write_reg(REG_BATCH, 8'd4);
				hold_req = ~hold_req;
				for (int i = 0; i < 40; i++)
					push_sample(pick_sample(), pick_sample(), pick_sample(), pick_tick());
				settle();
			end
			phase_items = 0;
			while (phase_items < 600) begin
				fac  = pick_factor();
				blen = pick_batch();
				n    = (fac == 255) ? 300 : $urandom_range(30, 90);
				run_segment(fac, blen, n);
				phase_items += n;
			end
		end

		settle();
		$display("run covered %0d input words, %0d averages checked, %0d register writes",
			words_in, means_checked, reg_writes);
		if (errors == 0 && mean_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d averages missing", errors, mean_q.size());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
